>>> design/fnvrc_pkg.sv
// ----------------------------------------------------------------------------
// fnvrc_pkg: shared types and constants for the FNV-1a record checksum engine
// Request payloads, result payloads, register indexes, status codes and the
// shift schedule of the FNV prime.
// ----------------------------------------------------------------------------
`default_nettype none

package fnvrc_pkg;

  localparam int LEN_WIDTH = 23;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = LEN_WIDTH + CFG_W;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

  localparam logic [CFG_W-1:0] MIN_LEN_RST = CFG_W'(74);
  localparam logic [CFG_W-1:0] MAX_LEN_RST = CFG_W'(4 * 1000 * 1000);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_LEN      = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic MODE_GEN    = 1'b0;
  localparam logic MODE_VERIFY = 1'b1;

  localparam logic [2:0] MUL_LAST = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [63:0] height;
    logic [7:0]  data_byte;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [63:0] hash_value;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // prime = 2^40 + 2^8 + 0xb3
  function automatic logic [5:0] fnv_shift(input logic [2:0] step);
    logic [5:0] s;
    case (step)
      3'd0: s = 6'd0;
      3'd1: s = 6'd1;
      3'd2: s = 6'd4;
      3'd3: s = 6'd5;
      3'd4: s = 6'd7;
      3'd5: s = 6'd8;
      3'd6: s = 6'd40;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/fnvrc_mul.sv
// ----------------------------------------------------------------------------
// fnvrc_mul: shift-add multiplier by the FNV-1a 64-bit prime
// One 64-bit adder accumulates a shifted copy of the operand per cycle over
// the seven set bits of the prime; the product is truncated to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvrc_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fnvrc_pkg::mul_req_t req,
  output fnvrc_pkg::mul_rsp_t      rsp
);
  import fnvrc_pkg::*;

  logic        run_r;
  logic        done_r;
  logic [2:0]  step_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;

  assign acc_nxt = acc_r + (x_r << fnv_shift(step_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == MUL_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.operand;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

`default_nettype wire

>>> design/fnv1a_record_checksum_engine.sv
// ----------------------------------------------------------------------------
// fnv1a_record_checksum_engine: 64-bit FNV-1a record checksum
// Hashes the record height and payload, emits or verifies the checksum and
// flags payload lengths outside the configured range.
// ----------------------------------------------------------------------------
// A start request hashes the height as eight bytes; a payload byte is hashed
// once and a stored checksum byte in verify mode is only stored. Hashed bytes
// go through the shared shift-add multiplier, which needs seven adder passes
// per byte. The block takes no request while a byte is in the multiplier or
// while results of a finished record are still being delivered: eight
// checksum bytes in generate mode, one status result in verify mode. No
// clearing pass is needed after reset.
`default_nettype none

module fnv1a_record_checksum_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire fnvrc_pkg::in_t                    in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output fnvrc_pkg::out_t                        out_data,
  input  wire logic                              cfg_we,
  input  wire logic [fnvrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fnvrc_pkg::CFG_W-1:0]       cfg_wdata
);
  import fnvrc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_OUT
  } state_t;

  state_t               state_r,     state_nxt;
  in_t                  item_r,      item_nxt;
  logic [63:0]          hash_r,      hash_nxt;
  logic [63:0]          chk_r,       chk_nxt;
  logic [3:0]           hdr_r,       hdr_nxt;
  logic [LEN_WIDTH-1:0] cnt_r,       cnt_nxt;
  logic [2:0]           hb_r,        hb_nxt;
  logic                 prefix_r,    prefix_nxt;
  logic                 go_r,        go_nxt;
  logic [63:0]          operand_r,   operand_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r,       out_nxt;
  logic [2:0]           emit_r,      emit_nxt;

  logic                 mode_r;
  logic [CFG_W-1:0]     min_len_r;
  logic [CFG_W-1:0]     max_len_r;

  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;

  logic                 fin;
  logic [63:0]          fin_hash;
  logic [63:0]          fin_chk;
  logic                 len_bad;
  logic [2:0]           emit_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_GEN;
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_wdata[0];
        CFG_MIN_LEN: min_len_r <= cfg_wdata;
        CFG_MAX_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mul_req.start   = go_r;
  assign mul_req.operand = operand_r;

  fnvrc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign emit_sel  = 3'd6 - emit_r;

  assign len_bad = (CMP_W'(cnt_r) < CMP_W'(min_len_r)) ||
                   (CMP_W'(cnt_r) > CMP_W'(max_len_r));

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    hash_nxt      = hash_r;
    chk_nxt       = chk_r;
    hdr_nxt       = hdr_r;
    cnt_nxt       = cnt_r;
    hb_nxt        = hb_r;
    prefix_nxt    = prefix_r;
    go_nxt        = 1'b0;
    operand_nxt   = operand_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    emit_nxt      = emit_r;
    fin           = 1'b0;
    fin_hash      = hash_r;
    fin_chk       = chk_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.cmd == CMD_START) begin
            hash_nxt    = FNV_BASIS;
            chk_nxt     = '0;
            hdr_nxt     = '0;
            cnt_nxt     = '0;
            hb_nxt      = '0;
            prefix_nxt  = 1'b1;
            operand_nxt = FNV_BASIS ^ {56'd0, in_data.height[7:0]};
            go_nxt      = 1'b1;
            state_nxt   = S_MUL;
          end else if (mode_r == MODE_VERIFY && !hdr_r[3]) begin
            chk_nxt = {chk_r[55:0], in_data.data_byte};
            hdr_nxt = hdr_r + 4'd1;
            if (in_data.last) begin
              fin     = 1'b1;
              fin_chk = chk_nxt;
            end
          end else begin
            operand_nxt = hash_r ^ {56'd0, in_data.data_byte};
            if (cnt_r != LEN_MAX) begin
              cnt_nxt = cnt_r + LEN_WIDTH'(1);
            end
            prefix_nxt = 1'b0;
            go_nxt     = 1'b1;
            state_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          hash_nxt = mul_rsp.product;
          if (prefix_r) begin
            if (hb_r == 3'd7) begin
              state_nxt = S_IDLE;
            end else begin
              hb_nxt      = hb_r + 3'd1;
              operand_nxt = mul_rsp.product ^ {56'd0, item_r.height[{hb_nxt, 3'b000} +: 8]};
              go_nxt      = 1'b1;
            end
          end else if (item_r.last) begin
            fin      = 1'b1;
            fin_hash = mul_rsp.product;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_r.last_out) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            emit_nxt         = emit_r + 3'd1;
            out_nxt.out_byte = out_r.hash_value[{emit_sel, 3'b000} +: 8];
            out_nxt.last_out = (emit_r == 3'd6);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      out_valid_nxt      = 1'b1;
      out_nxt.hash_value = fin_hash;
      emit_nxt           = '0;
      if (mode_r == MODE_GEN) begin
        out_nxt.out_byte = fin_hash[63:56];
        out_nxt.status   = len_bad ? ST_LEN : ST_OK;
        out_nxt.last_out = 1'b0;
      end else begin
        out_nxt.out_byte = '0;
        out_nxt.status   = len_bad ? ST_LEN : ((fin_hash != fin_chk) ? ST_MISMATCH : ST_OK);
        out_nxt.last_out = 1'b1;
      end
      hash_nxt  = FNV_BASIS;
      chk_nxt   = '0;
      hdr_nxt   = '0;
      cnt_nxt   = '0;
      state_nxt = S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      item_r      <= '0;
      hash_r      <= FNV_BASIS;
      chk_r       <= '0;
      hdr_r       <= '0;
      cnt_r       <= '0;
      hb_r        <= '0;
      prefix_r    <= 1'b0;
      go_r        <= 1'b0;
      operand_r   <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      emit_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      hash_r      <= hash_nxt;
      chk_r       <= chk_nxt;
      hdr_r       <= hdr_nxt;
      cnt_r       <= cnt_nxt;
      hb_r        <= hb_nxt;
      prefix_r    <= prefix_nxt;
      go_r        <= go_nxt;
      operand_r   <= operand_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      emit_r      <= emit_nxt;
    end
  end

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> state_r == S_MUL)
    else $error("multiplier result outside multiply state");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("request taken while a result is pending");

  a_mismatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_MISMATCH) |-> out_data.last_out)
    else $error("mismatch status on a non-final result");

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r <= 4'd8)
    else $error("stored checksum byte count overrun");

  a_go_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |=> !go_r)
    else $error("multiplier start held for two cycles");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the FNV-1a record checksum engine
// Drives start and record-byte requests in bursts with random gaps while the
// result side stalls on its own pattern. A local FNV-1a model forecasts every
// checksum byte or verify status, and each result is compared field by field
// against the oldest forecast. Directed cases come first, then random records
// under several register settings in both generate and verify mode.
// ----------------------------------------------------------------------------

module tb_top;
  import fnvrc_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic                 reg_mode;
  logic [CFG_W-1:0]     reg_min_len;
  logic [CFG_W-1:0]     reg_max_len;
  logic [63:0]          rec_hash;
  logic [63:0]          rec_stored;
  int unsigned          rec_hdr_cnt;
  logic [LEN_WIDTH-1:0] rec_len;

  out_t pending_digests[$];
  out_t want;
  int   fail_count    = 0;
  int   requests_sent = 0;
  int   burst_left    = 0;
  int   cycle_count   = 0;
  bit   hold_results_req = 1'b0;

  fnv1a_record_checksum_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  function automatic in_t random_request();
    in_t req;
    req.cmd       = 1'($urandom);
    req.height    = {$urandom, $urandom};
    req.data_byte = 8'($urandom);
    req.last      = 1'($urandom);
    return req;
  endfunction

  function automatic in_t start_request(input logic [63:0] height);
    in_t req;
    req        = random_request();
    req.cmd    = CMD_START;
    req.height = height;
    return req;
  endfunction

  function automatic in_t byte_request(input logic [7:0] b, input logic last);
    in_t req;
    req           = random_request();
    req.cmd       = CMD_BYTE;
    req.data_byte = b;
    req.last      = last;
    return req;
  endfunction

  task automatic clear_record();
    rec_hash    = FNV_BASIS;
    rec_stored  = '0;
    rec_hdr_cnt = 0;
    rec_len     = '0;
  endtask

  task automatic apply_fnv_request(input in_t req);
    logic [63:0] h;
    logic        len_bad;
    logic [1:0]  st;
    out_t        res;
    if (req.cmd == CMD_START) begin
      clear_record();
      h = FNV_BASIS;
      for (int i = 0; i < 8; i++) h = fnv_step(h, req.height[8*i +: 8]);
      rec_hash = h;
      return;
    end
    if (reg_mode == MODE_VERIFY && rec_hdr_cnt < 8) begin
      rec_stored = {rec_stored[55:0], req.data_byte};
      rec_hdr_cnt++;
    end else begin
      rec_hash = fnv_step(rec_hash, req.data_byte);
      if (rec_len != LEN_MAX) rec_len++;
    end
    if (!req.last) return;
    len_bad = (rec_len < reg_min_len) || (rec_len > reg_max_len);
    if (reg_mode == MODE_GEN) begin
      st = len_bad ? ST_LEN : ST_OK;
      for (int i = 0; i < 8; i++) begin
        res.out_byte   = rec_hash[8*(7-i) +: 8];
        res.status     = st;
        res.hash_value = rec_hash;
        res.last_out   = (i == 7);
        pending_digests = {pending_digests, res};
      end
    end else begin
      if (len_bad) st = ST_LEN;
      else if (rec_hash != rec_stored) st = ST_MISMATCH;
      else st = ST_OK;
      res.out_byte   = 8'h00;
      res.status     = st;
      res.hash_value = rec_hash;
      res.last_out   = 1'b1;
      pending_digests = {pending_digests, res};
    end
    clear_record();
  endtask

  task automatic send_request(input in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    apply_fnv_request(req);
  endtask

  task automatic configure(input logic mode_val, input logic [CFG_W-1:0] min_val,
                           input logic [CFG_W-1:0] max_val);
    logic [CFG_W-1:0] mode_word;
    mode_word    = CFG_W'($urandom);
    mode_word[0] = mode_val;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_index <= CFG_MIN_LEN;
    cfg_wdata <= min_val;
    @(posedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= max_val;
    @(posedge clk);
    cfg_we      <= 1'b0;
    reg_mode    = mode_word[0];
    reg_min_len = min_val;
    reg_max_len = max_val;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // verify records carry the big-endian digest ahead of the payload
  task automatic send_record(input logic [63:0] height, input int len, input bit with_start,
                             input bit corrupt, input bit truncated);
    logic [7:0]  payload[$];
    logic [63:0] digest;
    digest = FNV_BASIS;
    if (with_start)
      for (int i = 0; i < 8; i++) digest = fnv_step(digest, height[8*i +: 8]);
    for (int i = 0; i < len; i++) begin
      payload = {payload, 8'($urandom)};
      digest = fnv_step(digest, payload[i]);
    end
    if (corrupt) digest = digest ^ (64'd1 << $urandom_range(0, 63));
    if (with_start) send_request(start_request(height));
    if (reg_mode == MODE_VERIFY)
      for (int i = 0; i < 8; i++) send_request(byte_request(digest[8*(7-i) +: 8], 1'b0));
    for (int i = 0; i < len; i++)
      send_request(byte_request(payload[i], (i == len - 1) && !truncated));
  endtask

  task automatic test_reset_defaults();
    send_request(byte_request(8'h00, 1'b0));
    send_request(byte_request(8'hff, 1'b1));
    wait_idle();
  endtask

  task automatic test_generate_extremes();
    configure(MODE_GEN, '0, '1);
    send_request(in_t'{cmd: CMD_START, height: '1, data_byte: 8'h00, last: 1'b1});
    send_request(in_t'{cmd: CMD_BYTE, height: '0, data_byte: 8'hff, last: 1'b1});
    send_request(in_t'{cmd: CMD_START, height: '0, data_byte: 8'hff, last: 1'b0});
    send_request(in_t'{cmd: CMD_BYTE, height: '1, data_byte: 8'h00, last: 1'b1});
    wait_idle();
  endtask

  task automatic test_verify_match();
    configure(MODE_VERIFY, CFG_W'(1), CFG_W'(1));
    send_record({$urandom, $urandom}, 1, 1'b1, 1'b0, 1'b0);
    wait_idle();
  endtask

  // end inside the stored digest with an empty length range
  task automatic test_short_verify_record();
    configure(MODE_VERIFY, '1, '0);
    send_request(start_request({$urandom, $urandom}));
    send_request(byte_request(8'($urandom), 1'b0));
    send_request(byte_request(8'($urandom), 1'b1));
    wait_idle();
  endtask

  task automatic test_mode_switch();
    configure(MODE_VERIFY, '0, '1);
    send_request(start_request({$urandom, $urandom}));
    send_request(byte_request(8'($urandom), 1'b0));
    send_request(byte_request(8'($urandom), 1'b0));
    wait_idle();
    configure(MODE_GEN, '0, '1);
    send_request(byte_request(8'($urandom), 1'b1));
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    configure(MODE_GEN, '0, '1);
    hold_results_req = 1'b1;
    for (int i = 0; i < 3; i++) send_record({$urandom, $urandom}, 2, 1'b1, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_records(input logic mode_val, input logic [CFG_W-1:0] min_val,
                                     input logic [CFG_W-1:0] max_val, input int n_items);
    int target;
    int pick;
    int len;
    configure(mode_val, min_val, max_val);
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      pick = $urandom_range(0, 9);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (pick < 7)
        send_record({$urandom, $urandom}, len, 1'b1, $urandom_range(0, 3) == 0, 1'b0);
      else if (pick == 7)
        send_record({$urandom, $urandom}, len, 1'($urandom), 1'($urandom), 1'($urandom));
      else
        repeat ($urandom_range(1, 3)) send_request(random_request());
    end
    wait_idle();
  endtask

  initial begin : result_sink
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_results_req) begin
        hold_results_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      phase = (phase + 1) % 64;
      if (phase < 20) out_ready <= 1'b1;
      else if (phase < 40) out_ready <= phase[1];
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_digests.size() == 0) begin
        $error("result with no request pending: out_byte %0h status %0d",
               out_data.out_byte, out_data.status);
        fail_count++;
      end else begin
        want = pending_digests.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, out_data.out_byte);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.hash_value !== want.hash_value) begin
          $error("hash_value: expected %0h, actual %0h", want.hash_value,
                 out_data.hash_value);
          fail_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, out_data.last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    reg_mode    = MODE_GEN;
    reg_min_len = MIN_LEN_RST;
    reg_max_len = MAX_LEN_RST;
    clear_record();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_generate_extremes();
    test_verify_match();
    test_short_verify_record();
    test_mode_switch();
    test_output_backpressure();
    test_random_records(MODE_GEN, CFG_W'($urandom_range(0, 4)),
                        CFG_W'($urandom_range(8, 20)), 15);
    test_random_records(MODE_VERIFY, CFG_W'($urandom_range(1, 3)),
                        CFG_W'($urandom_range(6, 16)), 15);
    test_random_records(MODE_GEN, CFG_W'($urandom_range(2, 6)), '1, 10);
    test_random_records(MODE_VERIFY, '0, '1, 15);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
design/fnvrc_pkg.sv
design/fnvrc_mul.sv
design/fnv1a_record_checksum_engine.sv
sim/tb_top.sv
